// ----- design/pfi_pkg.sv -----
// Shared types, constants and the round/saturate function for the 2x polyphase
// FIR interpolator. No dependencies; every other file in this folder uses it.
package pfi_pkg;

  localparam int SAMPLE_W = 16;
  localparam int TAPS     = 16;
  // Largest |sum| is below 2^31 for either phase, so 33 signed bits hold it
  localparam int ACC_W    = 33;
  localparam int SHIFT_Q  = 15;
  localparam int Q_W      = ACC_W + 1 - SHIFT_Q;

  localparam logic signed [ACC_W:0]   ROUND_TERM = (ACC_W + 1)'(16384);
  localparam logic signed [Q_W-1:0]   Q_MAX      = Q_W'(32767);
  localparam logic signed [Q_W-1:0]   Q_MIN      = -Q_W'(32768);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  // One partial sum per phase, handed from cell to cell
  typedef struct packed {
    acc_t even;
    acc_t odd;
  } psum_t;

  typedef enum logic [1:0] {
    PAIR_EMPTY,
    PAIR_EVEN,
    PAIR_ODD
  } pair_state_t;

  // Phase 0: 16 taps. Phase 1: 15 taps, padded with a zero in the last cell.
  localparam sample_t COEF_EVEN [TAPS] = '{
    16'sd0, -16'sd12, 16'sd23, 16'sd73, -16'sd533, 16'sd1859, -16'sd5262, 16'sd20237,
    16'sd20235, -16'sd5262, 16'sd1859, -16'sd533, 16'sd73, 16'sd23, -16'sd12, 16'sd0
  };

  localparam sample_t COEF_ODD [TAPS] = '{
    16'sd5, -16'sd66, 16'sd271, -16'sd718, 16'sd1434, -16'sd2288, 16'sd2999, 16'sd29494,
    16'sd2999, -16'sd2288, 16'sd1434, -16'sd718, 16'sd271, -16'sd66, 16'sd5, 16'sd0
  };

  // Add half an LSB, floor-shift by 15, clamp to 16 bits
  function automatic sample_t round_sat(input acc_t acc);
    logic signed [ACC_W:0] biased;
    logic signed [Q_W-1:0] q;
    sample_t               res;
    biased = {acc[ACC_W-1], acc} + ROUND_TERM;
    q      = $signed(biased[ACC_W:SHIFT_Q]);
    if (q > Q_MAX) begin
      res = sample_t'(Q_MAX);
    end else if (q < Q_MIN) begin
      res = sample_t'(Q_MIN);
    end else begin
      res = q[SAMPLE_W-1:0];
    end
    return res;
  endfunction

endpackage

// ----- design/pfi_if.sv -----
// Valid/ready channel interfaces for the interpolator's input and output.
// Depends on pfi_pkg for the sample type.
interface pfi_in_if;
  logic             valid;
  logic             ready;
  pfi_pkg::sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface pfi_out_if;
  logic             valid;
  logic             ready;
  pfi_pkg::sample_t sample_out;
  logic             last;

  modport source (output valid, output sample_out, output last, input ready);
  modport sink   (input valid, input sample_out, input last, output ready);
endinterface

// ----- design/pfi_cell.sv -----
// One tap cell of the transposed-form filter chain: multiplies the new sample
// by its two phase coefficients and adds the neighbour's partial sums. Uses pfi_pkg.
module pfi_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift_en,
  input  pfi_pkg::sample_t sample,
  input  pfi_pkg::sample_t coef_even,
  input  pfi_pkg::sample_t coef_odd,
  input  pfi_pkg::psum_t   sum_in,
  output pfi_pkg::psum_t   sum_out
);

  logic signed [2*pfi_pkg::SAMPLE_W-1:0] prod_even;
  logic signed [2*pfi_pkg::SAMPLE_W-1:0] prod_odd;
  pfi_pkg::psum_t                        psum;
  pfi_pkg::psum_t                        psum_next;

  assign prod_even = sample * coef_even;
  assign prod_odd  = sample * coef_odd;

  always_comb begin
    psum_next.even = sum_in.even + pfi_pkg::ACC_W'(prod_even);
    psum_next.odd  = sum_in.odd + pfi_pkg::ACC_W'(prod_odd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      psum <= '0;
    end else if (shift_en) begin
      psum <= psum_next;
    end
  end

  assign sum_out = psum;

endmodule

// ----- design/pfi_pair_out.sv -----
// Output stage: rounds and saturates both phase sums on load and hands them
// out as an even/odd beat pair. Uses pfi_pkg and pfi_out_if.
module pfi_pair_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  pfi_pkg::psum_t    sums,
  output logic              can_load,
  pfi_out_if.source         dout
);

  pfi_pkg::pair_state_t state;
  pfi_pkg::pair_state_t state_next;
  pfi_pkg::sample_t     even_q;
  pfi_pkg::sample_t     odd_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfi_pkg::PAIR_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      even_q <= pfi_pkg::round_sat(sums.even);
      odd_q  <= pfi_pkg::round_sat(sums.odd);
    end
  end

  always_comb begin
    state_next      = state;
    can_load        = 1'b0;
    dout.valid      = 1'b0;
    dout.last       = 1'b0;
    dout.sample_out = even_q;
    case (state)
      pfi_pkg::PAIR_EMPTY: begin
        can_load = 1'b1;
        if (load) begin
          state_next = pfi_pkg::PAIR_EVEN;
        end
      end
      pfi_pkg::PAIR_EVEN: begin
        dout.valid = 1'b1;
        if (dout.ready) begin
          state_next = pfi_pkg::PAIR_ODD;
        end
      end
      pfi_pkg::PAIR_ODD: begin
        dout.valid      = 1'b1;
        dout.last       = 1'b1;
        dout.sample_out = odd_q;
        // take the next sample as the closing beat leaves
        can_load        = dout.ready;
        if (load) begin
          state_next = pfi_pkg::PAIR_EVEN;
        end else if (dout.ready) begin
          state_next = pfi_pkg::PAIR_EMPTY;
        end
      end
      default: begin
        state_next = pfi_pkg::PAIR_EMPTY;
      end
    endcase
  end

endmodule

// ----- design/polyphase_fir_interpolator_1to2.sv -----
// 2x polyphase FIR interpolator, Q15, as a row of 16 transposed-form tap cells.
// The even beat is valid the cycle after a sample is accepted; the odd beat
// follows once the even beat is taken. The beats share one output channel, so
// a new sample is taken only while the output stage is empty or as the odd
// beat leaves. Reset: synchronous; clears all partial sums (an all-zero history)
// and empties the output stage. Uses pfi_pkg, pfi_if, pfi_cell and pfi_pair_out.
module polyphase_fir_interpolator_1to2 (
  input  logic      clk,
  input  logic      rst,
  pfi_in_if.sink    din,
  pfi_out_if.source dout
);

  pfi_pkg::psum_t chain [pfi_pkg::TAPS+1];
  logic           can_load;
  logic           load;

  assign din.ready = can_load;
  assign load      = din.valid && can_load;

  assign chain[pfi_pkg::TAPS] = '0;

  // Cell k feeds cell k-1; cell 0 holds both phase sums over the history
  for (genvar k = 0; k < pfi_pkg::TAPS; k++) begin : g_cell
    pfi_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift_en  (load),
      .sample    (din.sample_in),
      .coef_even (pfi_pkg::COEF_EVEN[k]),
      .coef_odd  (pfi_pkg::COEF_ODD[k]),
      .sum_in    (chain[k+1]),
      .sum_out   (chain[k])
    );
  end

  pfi_pair_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .sums     (chain[0]),
    .can_load (can_load),
    .dout     (dout)
  );

  // An accepted sample opens a pair with the even beat
  a_even_after_load: assert property (@(posedge clk) disable iff (rst)
    din.valid && din.ready |=> dout.valid && !dout.last)
    else $error("even beat missing after sample beat");

  // No sample is taken while an even beat is still owed
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    din.valid && din.ready |-> !dout.valid || (dout.last && dout.ready))
    else $error("sample taken with results still pending");

  // The even beat is always followed by the odd beat
  a_odd_follows: assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.ready && !dout.last |=> dout.valid && dout.last)
    else $error("odd beat missing after even beat");

endmodule
